// ----- rtl/cdau_pkg.sv -----
`timescale 1ns / 1ps

package cdau_pkg;

    localparam int YEAR_WIDTH      = 14;
    localparam int DAY_COUNT_WIDTH = 23;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;

    localparam int DAYS_PER_YEAR = 365;
    localparam int MONTH_COUNT   = 12;
    localparam int FEBRUARY      = 2;

    // years are offset by a multiple of 400 so that every year is positive
    localparam int YEAR_HALF  = 2 ** (YEAR_WIDTH - 1);
    localparam int YEAR_SHIFT = 400 * (YEAR_HALF / 400 + 2);
    localparam int MIN_SY     = YEAR_SHIFT - YEAR_HALF;
    localparam int MAX_SY     = YEAR_SHIFT + YEAR_HALF - 1;
    localparam int SY_W       = $clog2(MAX_SY + 1);
    localparam int BIT_W      = $clog2(SY_W);

    localparam int DN_W  = SY_W + 9;
    localparam int REM_W = 9;
    localparam int NW    = ((DN_W > DAY_COUNT_WIDTH) ? DN_W : DAY_COUNT_WIDTH) + 1;
    localparam int DW    = (DN_W > DAY_COUNT_WIDTH) ? DN_W : DAY_COUNT_WIDTH;

    // reciprocal of 100, exact for every operand below 2**(SY_W + 1)
    localparam int DIV_SHIFT = SY_W + 9;
    localparam int RECIP_100 = (2 ** DIV_SHIFT + 99) / 100;
    localparam int PW        = SY_W + DIV_SHIFT + 1;

    localparam int MIN_DBY_QUAD = DAYS_PER_YEAR * MIN_SY + (MIN_SY + 3) / 4;
    localparam int MIN_DBY_GREG = MIN_DBY_QUAD - (MIN_SY + 99) / 100 + (MIN_SY + 399) / 400;

    localparam logic [DAY_COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_DBY    = 4'd2,
        OP_DN_A   = 4'd3,
        OP_DN_B   = 4'd4,
        OP_SUB    = 4'd5,
        OP_SEARCH = 4'd6,
        OP_REM    = 4'd7,
        OP_WALK   = 4'd8,
        OP_DIFF   = 4'd9,
        OP_OUT    = 4'd10
    } dp_op_t;

    typedef enum logic [1:0] {
        SRC_A     = 2'd0,
        SRC_B     = 2'd1,
        SRC_TRIAL = 2'd2,
        SRC_Y     = 2'd3
    } yu_src_t;

    typedef struct packed {
        dp_op_t  op;
        yu_src_t src;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic bit_zero;
        logic walk_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [REM_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [REM_W-1:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [SY_W-1:0] shift_year(input logic signed [YEAR_WIDTH-1:0] y);
        return SY_W'(YEAR_SHIFT) + SY_W'(y);
    endfunction

endpackage

// ----- rtl/cdau_ctrl.sv -----
`timescale 1ns / 1ps

module cdau_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cdau_pkg::dp_status_t status,
    output cdau_pkg::dp_cmd_t    cmd
);
    import cdau_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_A1   = 15'h0002,
        S_A2   = 15'h0004,
        S_A3   = 15'h0008,
        S_B1   = 15'h0010,
        S_B2   = 15'h0020,
        S_B3   = 15'h0040,
        S_DIFF = 15'h0080,
        S_NSUB = 15'h0100,
        S_T1   = 15'h0200,
        S_T2   = 15'h0400,
        S_Y1   = 15'h0800,
        S_Y2   = 15'h1000,
        S_WALK = 15'h2000,
        S_DONE = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.src    = SRC_A;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_A1;
                end
            end
            S_A1:
            begin
                cmd.src    = SRC_A;
                state_next = S_A2;
            end
            S_A2:
            begin
                cmd.op     = OP_DBY;
                state_next = S_A3;
            end
            S_A3:
            begin
                cmd.op     = OP_DN_A;
                state_next = status.mode ? S_B1 : S_NSUB;
            end
            S_B1:
            begin
                cmd.src    = SRC_B;
                state_next = S_B2;
            end
            S_B2:
            begin
                cmd.op     = OP_DBY;
                state_next = S_B3;
            end
            S_B3:
            begin
                cmd.op     = OP_DN_B;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_DONE;
            end
            S_NSUB:
            begin
                cmd.op     = OP_SUB;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.src    = SRC_TRIAL;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.op     = OP_SEARCH;
                cmd.src    = SRC_TRIAL;
                state_next = status.bit_zero ? S_Y1 : S_T1;
            end
            S_Y1:
            begin
                cmd.src    = SRC_Y;
                state_next = S_Y2;
            end
            S_Y2:
            begin
                cmd.op     = OP_REM;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (status.walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/cdau_datapath.sv -----
`timescale 1ns / 1ps

module cdau_datapath (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  cdau_pkg::dp_cmd_t                             cmd,
    output cdau_pkg::dp_status_t                          status,
    input  logic                                          cfg_we,
    input  logic                                          cfg_wdata,
    input  logic                                          mode,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_a,
    input  logic        [cdau_pkg::MONTH_W-1:0]           month_a,
    input  logic        [cdau_pkg::DAY_W-1:0]             day_a,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_b,
    input  logic        [cdau_pkg::MONTH_W-1:0]           month_b,
    input  logic        [cdau_pkg::DAY_W-1:0]             day_b,
    input  logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   day_count,
    input  logic                                          out_ready,
    output logic                                          out_valid,
    output logic signed [cdau_pkg::YEAR_WIDTH-1:0]        result_year,
    output logic        [cdau_pkg::MONTH_W-1:0]           result_month,
    output logic        [cdau_pkg::DAY_W-1:0]             result_day,
    output logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   days_apart,
    output logic                                          date_error
);
    import cdau_pkg::*;

    logic                        leap_rule_reg;
    logic                        out_valid_reg;

    logic                        mode_reg;
    logic signed [YEAR_WIDTH-1:0] year_a_reg, year_b_reg;
    logic [MONTH_W-1:0]          month_a_reg, month_b_reg;
    logic [DAY_W-1:0]            day_a_reg, day_b_reg;
    logic [DAY_COUNT_WIDTH-1:0]  day_count_reg;

    logic [SY_W-1:0]             yu_in;
    logic [SY_W:0]               y_plus3, y_plus99;
    logic [PW-1:0]               prod_floor, prod_ceil;
    logic [DN_W-1:0]             p365_next, p365_reg;
    logic [SY_W-1:0]             q4_next, q4_reg;
    logic [SY_W-1:0]             q100_next, q100_reg;
    logic [SY_W-1:0]             q100c_next, q100c_reg;
    logic [1:0]                  ylow_reg;

    logic [SY_W-1:0]             q400, q400c;
    logic [DN_W-1:0]             dby;
    logic                        leap;

    logic [DN_W-1:0]             dby_reg;
    logic                        leap_reg;
    logic [DN_W-1:0]             dn_a_reg, dn_b_reg;
    logic [MONTH_W-1:0]          dn_month;
    logic [DAY_W-1:0]            dn_day;
    logic [DN_W-1:0]             dn;
    logic                        date_ok;

    logic signed [NW-1:0]        n_full, n_min;
    logic                        n_low;
    logic [DN_W-1:0]             n_reg;

    logic [SY_W-1:0]             search_y_reg, trial;
    logic [BIT_W-1:0]            bit_reg;

    logic [REM_W-1:0]            rem_reg;
    logic [MONTH_W-1:0]          month_reg;
    logic [DAY_W-1:0]            walk_len;
    logic                        walk_done;

    logic [DN_W-1:0]             diff_abs;
    logic [DAY_COUNT_WIDTH-1:0]  diff_sat, diff_reg;
    logic                        err_reg;

    logic signed [YEAR_WIDTH-1:0] result_year_reg;
    logic [MONTH_W-1:0]          result_month_reg;
    logic [DAY_W-1:0]            result_day_reg;
    logic [DAY_COUNT_WIDTH-1:0]  days_apart_reg;
    logic                        date_error_reg;

    // year unit, first stage: constant products
    assign trial = search_y_reg | (SY_W'(1) << bit_reg);

    always_comb
    begin
        unique case (cmd.src)
            SRC_A:     yu_in = shift_year(year_a_reg);
            SRC_B:     yu_in = shift_year(year_b_reg);
            SRC_TRIAL: yu_in = trial;
            SRC_Y:     yu_in = search_y_reg;
        endcase
    end

    assign y_plus3    = (SY_W+1)'(yu_in) + (SY_W+1)'(3);
    assign y_plus99   = (SY_W+1)'(yu_in) + (SY_W+1)'(99);
    assign prod_floor = PW'(yu_in) * PW'(RECIP_100);
    assign prod_ceil  = PW'(y_plus99) * PW'(RECIP_100);
    assign p365_next  = DN_W'(yu_in) * DN_W'(DAYS_PER_YEAR);
    assign q4_next    = SY_W'(y_plus3 >> 2);
    assign q100_next  = prod_floor[DIV_SHIFT +: SY_W];
    assign q100c_next = prod_ceil[DIV_SHIFT +: SY_W];

    // year unit, second stage: days before the year and leap flag
    assign q400  = q100_reg >> 2;
    assign q400c = SY_W'(((SY_W+1)'(q100c_reg) + (SY_W+1)'(3)) >> 2);
    assign dby   = p365_reg + DN_W'(q4_reg)
                 + (leap_rule_reg ? (DN_W'(q400c) - DN_W'(q100c_reg)) : '0);
    assign leap  = (ylow_reg == 2'b00)
                 && !(leap_rule_reg && (q100_reg == q100c_reg) && (q400 != q400c));

    // day number and validity of one date
    assign dn_month = (cmd.op == OP_DN_B) ? month_b_reg : month_a_reg;
    assign dn_day   = (cmd.op == OP_DN_B) ? day_b_reg : day_a_reg;
    assign dn       = dby_reg + DN_W'(month_start(dn_month)) + DN_W'(dn_day) - DN_W'(1)
                    + DN_W'(leap_reg && (dn_month > MONTH_W'(FEBRUARY)));
    assign date_ok  = (dn_day != '0) && (dn_day <= month_days(dn_month, leap_reg));

    assign n_full = $signed(NW'(dn_a_reg)) - $signed(NW'(day_count_reg));
    assign n_min  = leap_rule_reg ? NW'(MIN_DBY_GREG) : NW'(MIN_DBY_QUAD);
    assign n_low  = n_full < n_min;

    assign walk_len  = month_days(month_reg, leap_reg);
    assign walk_done = (month_reg == MONTH_W'(MONTH_COUNT)) || (rem_reg < REM_W'(walk_len));

    assign diff_abs = (dn_a_reg > dn_b_reg) ? (dn_a_reg - dn_b_reg) : (dn_b_reg - dn_a_reg);
    assign diff_sat = (DW'(diff_abs) > DW'(COUNT_MAX)) ? COUNT_MAX
                                                        : DAY_COUNT_WIDTH'(diff_abs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_rule_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                leap_rule_reg <= cfg_wdata;
            end
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p365_reg  <= p365_next;
        q4_reg    <= q4_next;
        q100_reg  <= q100_next;
        q100c_reg <= q100c_next;
        ylow_reg  <= yu_in[1:0];
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg      <= mode;
                year_a_reg    <= year_a;
                month_a_reg   <= month_a;
                day_a_reg     <= day_a;
                year_b_reg    <= year_b;
                month_b_reg   <= month_b;
                day_b_reg     <= day_b;
                day_count_reg <= day_count;
                err_reg       <= 1'b0;
            end
            OP_DBY:
            begin
                dby_reg  <= dby;
                leap_reg <= leap;
            end
            OP_DN_A:
            begin
                dn_a_reg <= dn;
                err_reg  <= err_reg | !date_ok;
            end
            OP_DN_B:
            begin
                dn_b_reg <= dn;
                err_reg  <= err_reg | !date_ok;
            end
            OP_SUB:
            begin
                n_reg        <= n_full[DN_W-1:0];
                err_reg      <= err_reg | n_low;
                search_y_reg <= '0;
                bit_reg      <= BIT_W'(SY_W - 1);
            end
            OP_SEARCH:
            begin
                if (dby <= n_reg)
                begin
                    search_y_reg <= trial;
                end
                bit_reg <= bit_reg - BIT_W'(1);
            end
            OP_REM:
            begin
                rem_reg   <= REM_W'(n_reg - dby);
                leap_reg  <= leap;
                month_reg <= MONTH_W'(1);
            end
            OP_WALK:
            begin
                if (!walk_done)
                begin
                    rem_reg   <= rem_reg - REM_W'(walk_len);
                    month_reg <= month_reg + MONTH_W'(1);
                end
            end
            OP_DIFF:
            begin
                diff_reg <= diff_sat;
            end
            OP_OUT:
            begin
                date_error_reg <= err_reg;
                if (err_reg || mode_reg)
                begin
                    result_year_reg  <= '0;
                    result_month_reg <= '0;
                    result_day_reg   <= '0;
                end
                else
                begin
                    result_year_reg  <= $signed(YEAR_WIDTH'(search_y_reg - SY_W'(YEAR_SHIFT)));
                    result_month_reg <= month_reg;
                    result_day_reg   <= DAY_W'(rem_reg + REM_W'(1));
                end
                days_apart_reg <= (err_reg || !mode_reg) ? '0 : diff_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.mode      = mode_reg;
    assign status.bit_zero  = (bit_reg == '0);
    assign status.walk_done = walk_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign result_year  = result_year_reg;
    assign result_month = result_month_reg;
    assign result_day   = result_day_reg;
    assign days_apart   = days_apart_reg;
    assign date_error   = date_error_reg;

endmodule

// ----- rtl/calendar_date_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// channel   signals                                       transfer when
// in        in_valid, in_ready, mode, year_a .. day_count in_valid & in_ready
// out       out_valid, out_ready, result_year .. date_error out_valid & out_ready
// cfg       cfg_we, cfg_wdata (leap_rule)                 cfg_we
//
// one item at a time; in_ready is high only while the unit is free
// day subtraction: a year search (one year bit per pass through the shared year unit),
//   then a month walk (one month a cycle)
// a held result does not block the next input transfer; rst_n clears control
// and the leap rule asynchronously, no clearing pass is needed

module calendar_date_arithmetic_unit (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic                                          cfg_wdata,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic                                          mode,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_a,
    input  logic        [cdau_pkg::MONTH_W-1:0]           month_a,
    input  logic        [cdau_pkg::DAY_W-1:0]             day_a,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_b,
    input  logic        [cdau_pkg::MONTH_W-1:0]           month_b,
    input  logic        [cdau_pkg::DAY_W-1:0]             day_b,
    input  logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   day_count,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [cdau_pkg::YEAR_WIDTH-1:0]        result_year,
    output logic        [cdau_pkg::MONTH_W-1:0]           result_month,
    output logic        [cdau_pkg::DAY_W-1:0]             result_day,
    output logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   days_apart,
    output logic                                          date_error
);
    import cdau_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cdau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cdau_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mode         (mode),
        .year_a       (year_a),
        .month_a      (month_a),
        .day_a        (day_a),
        .year_b       (year_b),
        .month_b      (month_b),
        .day_b        (day_b),
        .day_count    (day_count),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .days_apart   (days_apart),
        .date_error   (date_error)
    );

endmodule

// ----- rtl/cdau_checker.sv -----
`timescale 1ns / 1ps

module cdau_checker (
    input logic                                          clk,
    input logic                                          rst_n,
    input logic                                          cfg_we,
    input logic                                          cfg_wdata,
    input logic                                          in_valid,
    input logic                                          in_ready,
    input logic                                          mode,
    input logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_a,
    input logic        [cdau_pkg::MONTH_W-1:0]           month_a,
    input logic        [cdau_pkg::DAY_W-1:0]             day_a,
    input logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_b,
    input logic        [cdau_pkg::MONTH_W-1:0]           month_b,
    input logic        [cdau_pkg::DAY_W-1:0]             day_b,
    input logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   day_count,
    input logic                                          out_valid,
    input logic                                          out_ready,
    input logic signed [cdau_pkg::YEAR_WIDTH-1:0]        result_year,
    input logic        [cdau_pkg::MONTH_W-1:0]           result_month,
    input logic        [cdau_pkg::DAY_W-1:0]             result_day,
    input logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   days_apart,
    input logic                                          date_error
);
    import cdau_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_year)
            && $stable(result_month) && $stable(result_day) && $stable(days_apart)
            && $stable(date_error))
        else $error("result changed while stalled");

    // one item in flight: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_error |-> result_year == '0 && result_month == '0
            && result_day == '0 && days_apart == '0)
        else $error("error result carries data");

    a_date_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !date_error |-> ((result_month == '0) == (result_day == '0))
            && result_month <= MONTH_W'(MONTH_COUNT))
        else $error("malformed result date");

    a_mode_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_month != '0 |-> days_apart == '0)
        else $error("date and distance both present");

endmodule

bind calendar_date_arithmetic_unit cdau_checker u_cdau_checker (.*);

// ----- bench/date_tb_pkg.sv -----
`timescale 1ns / 1ps

package date_tb_pkg;

    typedef enum bit {
        MODE_SUBTRACT = 1'b0,
        MODE_DISTANCE = 1'b1
    } date_mode_e;

    typedef enum bit {
        LEAP_QUAD      = 1'b0,
        LEAP_GREGORIAN = 1'b1
    } leap_rule_e;

endpackage

// ----- bench/date_result_checker.sv -----
`timescale 1ns / 1ps

module date_result_checker (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic                                          cfg_wdata,
    input  logic                                          in_valid,
    input  logic                                          in_ready,
    input  logic                                          mode,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_a,
    input  logic        [cdau_pkg::MONTH_W-1:0]           month_a,
    input  logic        [cdau_pkg::DAY_W-1:0]             day_a,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        year_b,
    input  logic        [cdau_pkg::MONTH_W-1:0]           month_b,
    input  logic        [cdau_pkg::DAY_W-1:0]             day_b,
    input  logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   day_count,
    input  logic                                          out_valid,
    input  logic                                          out_ready,
    input  logic signed [cdau_pkg::YEAR_WIDTH-1:0]        result_year,
    input  logic        [cdau_pkg::MONTH_W-1:0]           result_month,
    input  logic        [cdau_pkg::DAY_W-1:0]             result_day,
    input  logic        [cdau_pkg::DAY_COUNT_WIDTH-1:0]   days_apart,
    input  logic                                          date_error,
    output int                                            mismatches,
    output int                                            awaited
);
    import date_tb_pkg::*;

    localparam int YW = cdau_pkg::YEAR_WIDTH;
    localparam int CW = cdau_pkg::DAY_COUNT_WIDTH;

    // years are moved up by a multiple of 400 so that every year is positive
    localparam longint YEAR_HALF_SPAN = longint'(1) << (YW - 1);
    localparam longint YEAR_OFFSET    = 400 * (YEAR_HALF_SPAN / 400 + 2);
    localparam longint COUNT_LIMIT    = (longint'(1) << CW) - 1;

    typedef struct packed {
        logic [YW-1:0]                   year;
        logic [cdau_pkg::MONTH_W-1:0]    month;
        logic [cdau_pkg::DAY_W-1:0]      day;
        logic [CW-1:0]                   apart;
        logic                            err;
    } date_result_t;

    date_result_t expected_dates[$];
    date_result_t want;
    bit           leap_gregorian;

    function automatic bit leap_year(longint y, bit greg);
        if (y % 4 != 0)
            return 1'b0;
        if (greg && y % 100 == 0 && y % 400 != 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic longint days_to_year(longint y, bit greg);
        longint d;
        d = 365 * y + (y + 3) / 4;
        if (greg)
            d = d - (y + 99) / 100 + (y + 399) / 400;
        return d;
    endfunction

    function automatic int days_in_month(longint y, int m, bit greg);
        case (m)
            2:           return leap_year(y, greg) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit real_date(longint y, int m, int d, bit greg);
        if (m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= days_in_month(y, m, greg);
    endfunction

    function automatic longint date_number(longint y, int m, int d, bit greg);
        longint n;
        int     k;
        n = days_to_year(y, greg) + d - 1;
        for (k = 1; k < m; k++)
            n += days_in_month(y, k, greg);
        return n;
    endfunction

    function automatic date_result_t predict_date_result(
        logic md,
        logic signed [YW-1:0] ya, logic [3:0] ma, logic [4:0] da,
        logic signed [YW-1:0] yb, logic [3:0] mb, logic [4:0] db,
        logic [CW-1:0] cnt, bit greg);
        date_result_t r;
        longint       sa, sb, na, nb, n, y, rest, diff;
        int           m;
        r  = '0;
        sa = longint'(ya) + YEAR_OFFSET;
        sb = longint'(yb) + YEAR_OFFSET;
        if (!real_date(sa, int'(ma), int'(da), greg)
            || (md == MODE_DISTANCE && !real_date(sb, int'(mb), int'(db), greg)))
        begin
            r.err = 1'b1;
            return r;
        end
        if (md == MODE_SUBTRACT)
        begin
            n = date_number(sa, int'(ma), int'(da), greg) - longint'(cnt);
            if (n < days_to_year(YEAR_OFFSET - YEAR_HALF_SPAN, greg))
            begin
                r.err = 1'b1;
                return r;
            end
            y = greg ? (n * 400) / 146097 : (n * 4) / 1461;
            while (y > 0 && days_to_year(y, greg) > n)
                y--;
            while (days_to_year(y + 1, greg) <= n)
                y++;
            rest = n - days_to_year(y, greg);
            m = 1;
            while (m < 12 && rest >= days_in_month(y, m, greg))
            begin
                rest -= days_in_month(y, m, greg);
                m++;
            end
            r.year  = YW'(y - YEAR_OFFSET);
            r.month = 4'(m);
            r.day   = 5'(rest + 1);
        end
        else
        begin
            na     = date_number(sa, int'(ma), int'(da), greg);
            nb     = date_number(sb, int'(mb), int'(db), greg);
            diff   = (na > nb) ? na - nb : nb - na;
            r.apart = CW'((diff > COUNT_LIMIT) ? COUNT_LIMIT : diff);
        end
        return r;
    endfunction

    task automatic report_field(string field, longint exp_value, longint got_value);
        $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_value, got_value);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_gregorian <= 1'b0;
            expected_dates.delete();
            awaited <= 0;
        end
        else
        begin
            if (cfg_we)
                leap_gregorian <= cfg_wdata;
            if (in_valid && in_ready)
                expected_dates.push_back(predict_date_result(mode, year_a, month_a, day_a,
                    year_b, month_b, day_b, day_count, leap_gregorian));
            if (out_valid && out_ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (want.year !== result_year)
                        report_field("result_year", $signed(want.year), result_year);
                    if (want.month !== result_month)
                        report_field("result_month", want.month, result_month);
                    if (want.day !== result_day)
                        report_field("result_day", want.day, result_day);
                    if (want.apart !== days_apart)
                        report_field("days_apart", want.apart, days_apart);
                    if (want.err !== date_error)
                        report_field("date_error", want.err, date_error);
                end
            end
            awaited <= expected_dates.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import date_tb_pkg::*;

    localparam int YW           = cdau_pkg::YEAR_WIDTH;
    localparam int CW           = cdau_pkg::DAY_COUNT_WIDTH;
    localparam int YEAR_MIN     = -(2 ** (YW - 1));
    localparam int YEAR_MAX     = 2 ** (YW - 1) - 1;
    localparam int COUNT_TOP    = 2 ** CW - 1;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_DELAY = 60;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic                             cfg_wdata;
    logic                             in_valid;
    logic                             in_ready;
    logic                             mode;
    logic signed [YW-1:0]             year_a;
    logic        [3:0]                month_a;
    logic        [4:0]                day_a;
    logic signed [YW-1:0]             year_b;
    logic        [3:0]                month_b;
    logic        [4:0]                day_b;
    logic        [CW-1:0]             day_count;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [YW-1:0]             result_year;
    logic        [3:0]                result_month;
    logic        [4:0]                result_day;
    logic        [CW-1:0]             days_apart;
    logic                             date_error;

    int mismatches;
    int awaited;
    int stall_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int subtract_items;
    int distance_items;

    calendar_date_arithmetic_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .year_a       (year_a),
        .month_a      (month_a),
        .day_a        (day_a),
        .year_b       (year_b),
        .month_b      (month_b),
        .day_b        (day_b),
        .day_count    (day_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .days_apart   (days_apart),
        .date_error   (date_error)
    );

    date_result_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .year_a       (year_a),
        .month_a      (month_a),
        .day_a        (day_a),
        .year_b       (year_b),
        .month_b      (month_b),
        .day_b        (day_b),
        .day_count    (day_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .days_apart   (days_apart),
        .date_error   (date_error),
        .mismatches   (mismatches),
        .awaited      (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic int random_year();
        case ($urandom_range(3))
            0:       return int'($urandom_range(YEAR_MAX - YEAR_MIN)) + YEAR_MIN;
            1:       return 100 * (int'($urandom_range(160)) - 80) + int'($urandom_range(8)) - 4;
            2:       return $urandom_range(1) ? YEAR_MIN + int'($urandom_range(20))
                                              : YEAR_MAX - int'($urandom_range(20));
            default: return 1890 + int'($urandom_range(230));
        endcase
    endfunction

    function automatic int random_month();
        return ($urandom_range(99) < 8) ? int'($urandom_range(15)) : int'($urandom_range(12, 1));
    endfunction

    function automatic int random_day();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return $urandom_range(31);
        if (pick < 25)
            return $urandom_range(31, 29);
        return $urandom_range(28, 1);
    endfunction

    function automatic int random_count();
        case ($urandom_range(3))
            0:       return $urandom_range(60);
            1:       return $urandom_range(2000);
            2:       return $urandom_range(400000);
            default: return $urandom_range(COUNT_TOP);
        endcase
    endfunction

    task automatic send_date_item(date_mode_e md, int ya, int ma, int da,
                                  int yb, int mb, int db, int cnt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= md;
        year_a    <= YW'(ya);
        month_a   <= 4'(ma);
        day_a     <= 5'(da);
        year_b    <= YW'(yb);
        month_b   <= 4'(mb);
        day_b     <= 5'(db);
        day_count <= CW'(cnt);
        do
            @(posedge clk);
        while (!in_ready);
        if (md == MODE_SUBTRACT)
            subtract_items++;
        else
            distance_items++;
    endtask

    task automatic send_random_items(int count);
        int         k;
        int         ya;
        int         yb;
        date_mode_e md;
        for (k = 0; k < count; k++)
        begin
            md = date_mode_e'($urandom_range(1));
            ya = random_year();
            if (md == MODE_DISTANCE && $urandom_range(1))
                yb = ya + int'($urandom_range(6)) - 3;
            else
                yb = random_year();
            send_date_item(md, ya, random_month(), random_day(),
                           yb, random_month(), random_day(), random_count());
        end
    endtask

    // the unit must be idle before the leap rule changes
    task automatic write_leap_rule(leap_rule_e rule);
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_DELAY) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rule;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        in_valid       = 1'b0;
        mode           = 1'b0;
        year_a         = '0;
        month_a        = '0;
        day_a          = '0;
        year_b         = '0;
        month_b        = '0;
        day_b          = '0;
        day_count      = '0;
        tx_idle_pct    = 38;
        rx_idle_pct    = 38;
        subtract_items = 0;
        distance_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_leap_rule(LEAP_QUAD);
        send_date_item(MODE_SUBTRACT, YEAR_MIN, 1, 1, YEAR_MAX, 15, 31, 0);
        send_date_item(MODE_SUBTRACT, YEAR_MIN, 1, 1, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, YEAR_MIN, 1, 2, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, YEAR_MAX, 12, 31, 0, 0, 0, COUNT_TOP);
        send_date_item(MODE_SUBTRACT, YEAR_MAX, 12, 31, 0, 0, 0, 5900000);
        send_date_item(MODE_SUBTRACT, 2000, 2, 29, 0, 0, 0, 0);
        send_date_item(MODE_SUBTRACT, 2001, 2, 29, 0, 0, 0, 0);
        send_date_item(MODE_SUBTRACT, 2000, 3, 1, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, 1, 1, 1, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, -1, 3, 1, 0, 0, 0, 366);
        send_date_item(MODE_SUBTRACT, 2023, 0, 10, 0, 0, 0, 5);
        send_date_item(MODE_SUBTRACT, 2023, 13, 10, 0, 0, 0, 5);
        send_date_item(MODE_SUBTRACT, 2023, 15, 31, 0, 0, 0, 5);
        send_date_item(MODE_SUBTRACT, 2023, 4, 31, 0, 0, 0, 5);
        send_date_item(MODE_SUBTRACT, 2023, 1, 0, 0, 0, 0, 5);
        send_date_item(MODE_SUBTRACT, 2023, 1, 31, 0, 0, 0, 31);
        send_date_item(MODE_DISTANCE, 2023, 6, 15, 2023, 6, 15, COUNT_TOP);
        send_date_item(MODE_DISTANCE, YEAR_MIN, 1, 1, YEAR_MAX, 12, 31, 0);
        send_date_item(MODE_DISTANCE, YEAR_MAX, 12, 31, YEAR_MIN, 1, 1, 0);
        send_date_item(MODE_DISTANCE, 2023, 1, 1, 2023, 13, 1, 0);
        send_date_item(MODE_DISTANCE, 2023, 2, 30, 2023, 1, 1, 0);
        send_date_item(MODE_DISTANCE, 2024, 3, 1, 2023, 3, 1, 0);

        // century years only differ under the gregorian rule
        write_leap_rule(LEAP_GREGORIAN);
        send_date_item(MODE_SUBTRACT, 1900, 2, 29, 0, 0, 0, 0);
        send_date_item(MODE_SUBTRACT, 2000, 2, 29, 0, 0, 0, 0);
        send_date_item(MODE_SUBTRACT, 2100, 3, 1, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, -100, 3, 1, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, YEAR_MIN, 1, 1, 0, 0, 0, 1);
        send_date_item(MODE_SUBTRACT, YEAR_MAX, 12, 31, 0, 0, 0, 5900000);
        send_date_item(MODE_DISTANCE, 1900, 1, 1, 2000, 1, 1, 0);
        send_date_item(MODE_DISTANCE, YEAR_MIN, 1, 1, YEAR_MAX, 12, 31, COUNT_TOP);

        send_random_items(160);

        write_leap_rule(LEAP_QUAD);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_items(100);
        tx_idle_pct = 38;
        rx_idle_pct = 38;
        send_random_items(150);

        write_leap_rule(LEAP_GREGORIAN);
        send_random_items(240);

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_DELAY) @(posedge clk);

        $display("covered %0d day subtractions and %0d date distances", subtract_items,
                 distance_items);
        $display("under both leap rules, with idle and back-to-back traffic on both channels");
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
